// ===== src/tone_period_conflict_monitor_macros.svh =====
// Assertion helpers shared by the monitor RTL.
`ifndef TONE_PERIOD_CONFLICT_MONITOR_MACROS_SVH
`define TONE_PERIOD_CONFLICT_MONITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TPCM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tone period monitor: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TPCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tone period monitor: next-cycle check failed");

`endif

// ===== src/tpcm_pkg.sv =====
package tpcm_pkg;

   localparam int REGS_PER_CHIP  = 16;
   localparam int CHANS_PER_CHIP = 3;
   localparam int MASK_W         = 12;
   localparam int PERIOD_W       = 16;
   localparam int TRK_BITS       = 5;

   localparam logic [3:0] MIXER_REG  = 4'd7;
   localparam logic [3:0] VOLUME_REG = 4'd8;
   localparam int         ENV_BIT    = 4;
   localparam logic [3:0] LEVEL_MASK = 4'hf;
   localparam logic [PERIOD_W-1:0] PERIOD_ALL = 16'hFFFF;

   // configuration register indexes
   localparam logic [1:0] REG_CHIP_IS_AY    = 2'd0;
   localparam logic [1:0] REG_CHIPS_IN_USE  = 2'd1;
   localparam logic [1:0] REG_TRACKS_IN_USE = 2'd2;
   localparam logic [1:0] REG_HOLD_FRAMES   = 2'd3;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // per-chip read sequence steps
   localparam logic [3:0] SEQ_MIXER = 4'd0;
   localparam logic [3:0] SEQ_VOL0  = 4'd1;
   localparam logic [3:0] SEQ_VOL1  = 4'd2;
   localparam logic [3:0] SEQ_VOL2  = 4'd3;
   localparam logic [3:0] SEQ_LO0   = 4'd4;
   localparam logic [3:0] SEQ_HI0   = 4'd5;
   localparam logic [3:0] SEQ_LO1   = 4'd6;
   localparam logic [3:0] SEQ_HI1   = 4'd7;
   localparam logic [3:0] SEQ_LO2   = 4'd8;
   localparam logic [3:0] SEQ_HI2   = 4'd9;

   typedef logic [TRK_BITS-1:0] trk_type;

   typedef struct packed {
      logic                clear;
      logic                push;
      logic                usable;
      trk_type             trk;
      logic [PERIOD_W-1:0] period;
   } match_ctl_type;

   // chip register read at each sequence step
   function automatic logic [3:0] seq_reg(input logic [3:0] seq);
      logic [3:0] r;
      unique case (seq)
         SEQ_MIXER: r = MIXER_REG;
         SEQ_VOL0:  r = VOLUME_REG;
         SEQ_VOL1:  r = VOLUME_REG + 4'd1;
         SEQ_VOL2:  r = VOLUME_REG + 4'd2;
         SEQ_LO0:   r = 4'd0;
         SEQ_HI0:   r = 4'd1;
         SEQ_LO1:   r = 4'd2;
         SEQ_HI1:   r = 4'd3;
         SEQ_LO2:   r = 4'd4;
         SEQ_HI2:   r = 4'd5;
         default:   r = 4'd0;
      endcase
      return r;
   endfunction

   // channel uses tone: not pure noise, not pure envelope, not silent
   function automatic logic chan_tone(input logic [7:0] mixer, input logic [7:0] vol,
                                      input logic [1:0] chan);
      logic tone, noise, env, silent;
      tone   = !mixer[chan];
      noise  = !mixer[3'(chan) + 3'd3];
      env    = vol[ENV_BIT];
      silent = ((vol[3:0] & LEVEL_MASK) == 4'd0) && !env;
      return !((!tone && noise && !env) || (!tone && !noise && env) || silent);
   endfunction

endpackage

// ===== src/tpcm_ram.sv =====
module tpcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tpcm_match.sv =====
module tpcm_match #(
   parameter int MAX_TRACKS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tpcm_pkg::match_ctl_type ctl,
   output logic [MAX_TRACKS-1:0]   fresh_mask
);
   import tpcm_pkg::*;

   logic [PERIOD_W-1:0]   lane_period_ff [MAX_TRACKS];
   logic [PERIOD_W-1:0]   lane_period_in [MAX_TRACKS];
   logic [MAX_TRACKS-1:0] lane_valid_ff, lane_valid_in;
   logic [MAX_TRACKS-1:0] fresh_ff, fresh_in;
   logic [MAX_TRACKS-1:0] hit_vec, self_vec;

   // compare the incoming track against every track decoded so far
   always_comb begin
      for (int j = 0; j < MAX_TRACKS; j++) begin
         hit_vec[j]  = lane_valid_ff[j] &&
                       ((lane_period_ff[j] & PERIOD_ALL) == (ctl.period & PERIOD_ALL));
         self_vec[j] = (ctl.trk == TRK_BITS'(j));
      end
   end

   always_comb begin
      lane_valid_in = lane_valid_ff;
      fresh_in      = fresh_ff;
      for (int j = 0; j < MAX_TRACKS; j++) begin
         lane_period_in[j] = lane_period_ff[j];
      end
      if (ctl.clear) begin
         lane_valid_in = '0;
         fresh_in      = '0;
      end else if (ctl.push) begin
         if (ctl.usable && (|hit_vec)) begin
            fresh_in = fresh_ff | hit_vec | self_vec;
         end
         for (int j = 0; j < MAX_TRACKS; j++) begin
            if (self_vec[j]) begin
               lane_valid_in[j]  = ctl.usable;
               lane_period_in[j] = ctl.period;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= '0;
         fresh_ff      <= '0;
      end else begin
         lane_valid_ff <= lane_valid_in;
         fresh_ff      <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_TRACKS; j++) begin
         lane_period_ff[j] <= lane_period_in[j];
      end
   end

   assign fresh_mask = fresh_ff;

endmodule

// ===== src/tone_period_conflict_monitor.sv =====
// Channel   Direction  Handshake              Beat
// req_      in         req_valid/req_ready    register write or frame tick
// rsp_      out        rsp_valid/rsp_ready    warning and new-conflict masks (ticks)
// csr_      in         APB, pready always 1   four control registers
//
// With monitoring on, rsp_valid rises once a tick has been worked through (C chips and
// T tracks in use): ten shadow RAM reads per chip on its single read port, then one
// read-modify-write per warning counter. With monitoring off the reads and the
// counter updates are skipped and the tick goes straight to the response.
// Reset sets the controls to their defaults and clears warning flags and the shadow valid bits; no RAM sweep.
// A pending response stalls the next tick's completion; writes are taken while idle, but not while a tick is in flight.
`include "tone_period_conflict_monitor_macros.svh"

module tone_period_conflict_monitor #(
   parameter int MAX_CHIPS  = 4,
   parameter int MAX_TRACKS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic [1:0]                   req_chip_sel,
   input  logic [3:0]                   req_reg_addr,
   input  logic [7:0]                   req_reg_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tpcm_pkg::MASK_W-1:0]  rsp_warn_mask,
   output logic [tpcm_pkg::MASK_W-1:0]  rsp_new_conflict_mask,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [3:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import tpcm_pkg::*;

   localparam int SHADOW_DEPTH = MAX_CHIPS * REGS_PER_CHIP;
   localparam int SAW = $clog2(SHADOW_DEPTH);
   localparam int CLW = $clog2(MAX_CHIPS + 1);
   localparam int TLW = $clog2(MAX_TRACKS + 1);
   localparam int TW  = $clog2(MAX_TRACKS);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_DEC   = 2'd1;
   localparam logic [1:0] S_SWEEP = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   // control registers
   logic       ay_ff, ay_in;
   logic [2:0] chips_ff, chips_in;
   logic [3:0] tracks_ff, tracks_in;
   logic [7:0] hold_ff, hold_in;

   logic [1:0]     state_ff, state_in;
   logic [CLW-1:0] chips_lim_ff, chips_lim_in;
   logic [TLW-1:0] tracks_lim_ff, tracks_lim_in;
   logic [CLW-1:0] dchip_ff, dchip_in;
   logic [3:0]     dseq_ff, dseq_in;
   logic           rv_ff, rv_in;
   logic [3:0]     rseq_ff, rseq_in;
   logic           rsv_ff, rsv_in;
   trk_type        trk_ff, trk_in;
   logic [7:0]     mixer_ff, mixer_in;
   logic [7:0]     vol_ff [3];
   logic [7:0]     vol_in [3];
   logic [7:0]     lo_ff, lo_in;
   logic [TLW-1:0] scnt_ff, scnt_in;
   logic           wv_ff, wv_in;
   logic [TW-1:0]  widx_ff, widx_in;
   logic [MAX_TRACKS-1:0]   flag_ff, flag_in;
   logic [SHADOW_DEPTH-1:0] sv_bits_ff, sv_bits_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0] rsp_warn_ff, rsp_warn_in;
   logic [MASK_W-1:0] rsp_new_ff, rsp_new_in;

   logic cfg_wr, req_fire, dec_issue, sw_issue, rsp_load;
   logic [SAW-1:0] sh_wr_addr, sh_rd_addr;
   logic           sh_wr_en;
   logic [7:0]     sh_q, rd_byte;
   logic [7:0]     cnt_q, cnt_cur, cnt_new;
   logic [1:0]     chan;
   logic [PERIOD_W-1:0] period;
   logic [MAX_TRACKS-1:0] fresh_mask;
   logic [MASK_W-1:0]     warn_vec, fresh_vec;
   match_ctl_type         mctl;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_warn_mask         = rsp_warn_ff;
   assign rsp_new_conflict_mask = rsp_new_ff;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_CHIP_IS_AY:    csr_prdata = {31'd0, ay_ff};
         REG_CHIPS_IN_USE:  csr_prdata = {29'd0, chips_ff};
         REG_TRACKS_IN_USE: csr_prdata = {28'd0, tracks_ff};
         REG_HOLD_FRAMES:   csr_prdata = {24'd0, hold_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_comb begin
      ay_in     = ay_ff;
      chips_in  = chips_ff;
      tracks_in = tracks_ff;
      hold_in   = hold_ff;
      if (cfg_wr) begin
         unique case (csr_paddr[3:2])
            REG_CHIP_IS_AY:    ay_in     = csr_pwdata[0];
            REG_CHIPS_IN_USE:  chips_in  = csr_pwdata[2:0];
            REG_TRACKS_IN_USE: tracks_in = csr_pwdata[3:0];
            REG_HOLD_FRAMES:   hold_in   = csr_pwdata[7:0];
            default:           ay_in     = ay_ff;
         endcase
      end
   end

   // shadow register file
   assign sh_wr_en   = req_fire && (req_type == REQ_WRITE) && (int'(req_chip_sel) < MAX_CHIPS);
   assign sh_wr_addr = SAW'(int'(req_chip_sel) * REGS_PER_CHIP + int'(req_reg_addr));
   assign sh_rd_addr = SAW'(int'(dchip_ff) * REGS_PER_CHIP + int'(seq_reg(dseq_ff)));
   assign dec_issue  = (state_ff == S_DEC) && (dchip_ff < chips_lim_ff);

   tpcm_ram #(.WIDTH(8), .DEPTH(SHADOW_DEPTH)) u_shadow (
      .clock   (clock),
      .wr_en   (sh_wr_en),
      .wr_addr (sh_wr_addr),
      .wr_data (req_reg_value),
      .rd_en   (dec_issue),
      .rd_addr (sh_rd_addr),
      .rd_data (sh_q)
   );

   // never-written entries read as zero
   assign rd_byte = rsv_ff ? sh_q : 8'd0;

   // warning counter store; flag_ff doubles as its valid bit
   assign sw_issue = (state_ff == S_SWEEP) && (scnt_ff < tracks_lim_ff);
   assign cnt_cur  = flag_ff[widx_ff] ? cnt_q : 8'd0;
   assign cnt_new  = fresh_mask[widx_ff] ? hold_ff :
                     ((cnt_cur != 8'd0) ? cnt_cur - 8'd1 : 8'd0);

   tpcm_ram #(.WIDTH(8), .DEPTH(MAX_TRACKS)) u_counters (
      .clock   (clock),
      .wr_en   (wv_ff),
      .wr_addr (widx_ff),
      .wr_data (cnt_new),
      .rd_en   (sw_issue),
      .rd_addr (scnt_ff[TW-1:0]),
      .rd_data (cnt_q)
   );

   always_comb begin
      unique case (rseq_ff)
         SEQ_HI0: chan = 2'd0;
         SEQ_HI1: chan = 2'd1;
         SEQ_HI2: chan = 2'd2;
         default: chan = 2'd0;
      endcase
   end

   assign period = {rd_byte, lo_ff};

   always_comb begin
      mctl.clear  = req_fire && (req_type == REQ_TICK);
      mctl.push   = rv_ff && (rseq_ff == SEQ_HI0 || rseq_ff == SEQ_HI1 || rseq_ff == SEQ_HI2)
                    && (int'(trk_ff) < int'(tracks_lim_ff));
      mctl.usable = chan_tone(mixer_ff, vol_ff[chan], chan) && (period != '0);
      mctl.trk    = trk_ff;
      mctl.period = period;
   end

   tpcm_match #(.MAX_TRACKS(MAX_TRACKS)) u_match (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mctl),
      .fresh_mask (fresh_mask)
   );

   for (genvar b = 0; b < MASK_W; b++) begin : g_out
      if (b < MAX_TRACKS) begin : g_on
         assign warn_vec[b]  = flag_ff[b];
         assign fresh_vec[b] = fresh_mask[b];
      end else begin : g_off
         assign warn_vec[b]  = 1'b0;
         assign fresh_vec[b] = 1'b0;
      end
   end

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      chips_lim_in  = chips_lim_ff;
      tracks_lim_in = tracks_lim_ff;
      dchip_in      = dchip_ff;
      dseq_in       = dseq_ff;
      rv_in         = dec_issue;
      rseq_in       = dseq_ff;
      rsv_in        = sv_bits_ff[sh_rd_addr];
      trk_in        = trk_ff;
      mixer_in      = mixer_ff;
      vol_in        = vol_ff;
      lo_in         = lo_ff;
      scnt_in       = scnt_ff;
      wv_in         = sw_issue;
      widx_in       = scnt_ff[TW-1:0];
      flag_in       = flag_ff;
      sv_bits_in    = sv_bits_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_warn_in   = rsp_warn_ff;
      rsp_new_in    = rsp_new_ff;

      if (sh_wr_en) begin
         sv_bits_in[sh_wr_addr] = 1'b1;
      end

      // take apart the byte that came back from the shadow RAM
      if (rv_ff) begin
         unique case (rseq_ff)
            SEQ_MIXER: mixer_in  = rd_byte;
            SEQ_VOL0:  vol_in[0] = rd_byte;
            SEQ_VOL1:  vol_in[1] = rd_byte;
            SEQ_VOL2:  vol_in[2] = rd_byte;
            SEQ_LO0, SEQ_LO1, SEQ_LO2: lo_in = rd_byte;
            SEQ_HI0, SEQ_HI1, SEQ_HI2: trk_in = trk_ff + 1'b1;
            default: lo_in = lo_ff;
         endcase
      end

      if (wv_ff) begin
         flag_in[widx_ff] = (cnt_new != 8'd0);
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_type == REQ_TICK)) begin
               chips_lim_in  = (int'(chips_ff) > MAX_CHIPS) ? CLW'(MAX_CHIPS) : CLW'(chips_ff);
               tracks_lim_in = (int'(tracks_ff) > MAX_TRACKS) ? TLW'(MAX_TRACKS)
                                                              : TLW'(tracks_ff);
               dchip_in = '0;
               dseq_in  = SEQ_MIXER;
               trk_in   = '0;
               scnt_in  = '0;
               state_in = ay_ff ? S_DEC : S_DONE;
            end
         end
         S_DEC: begin
            if (dec_issue) begin
               // advance through ten reads per chip
               if (dseq_ff == SEQ_HI2) begin
                  dseq_in  = SEQ_MIXER;
                  dchip_in = dchip_ff + 1'b1;
               end else begin
                  dseq_in = dseq_ff + 4'd1;
               end
            end else if (!rv_ff) begin
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            if (sw_issue) begin
               scnt_in = scnt_ff + 1'b1;
            end else if (!wv_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_warn_in  = warn_vec;
               rsp_new_in   = fresh_vec;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ay_ff        <= 1'b1;
         chips_ff     <= 3'd1;
         tracks_ff    <= 4'd3;
         hold_ff      <= 8'd25;
         state_ff     <= S_IDLE;
         rv_ff        <= 1'b0;
         wv_ff        <= 1'b0;
         flag_ff      <= '0;
         sv_bits_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ay_ff        <= ay_in;
         chips_ff     <= chips_in;
         tracks_ff    <= tracks_in;
         hold_ff      <= hold_in;
         state_ff     <= state_in;
         rv_ff        <= rv_in;
         wv_ff        <= wv_in;
         flag_ff      <= flag_in;
         sv_bits_ff   <= sv_bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chips_lim_ff  <= chips_lim_in;
      tracks_lim_ff <= tracks_lim_in;
      dchip_ff      <= dchip_in;
      dseq_ff       <= dseq_in;
      rseq_ff       <= rseq_in;
      rsv_ff        <= rsv_in;
      trk_ff        <= trk_in;
      mixer_ff      <= mixer_in;
      vol_ff        <= vol_in;
      lo_ff         <= lo_in;
      scnt_ff       <= scnt_in;
      widx_ff       <= widx_in;
      rsp_warn_ff   <= rsp_warn_in;
      rsp_new_ff    <= rsp_new_in;
   end

   `TPCM_ASSERT_NEXT(a_tick_leaves_idle, clock, reset,
      req_valid && req_ready && (req_type == REQ_TICK), state_ff != S_IDLE)
   `TPCM_ASSERT_NOW(a_no_read_in_sweep, clock, reset,
      state_ff == S_SWEEP, !rv_ff)
   `TPCM_ASSERT_NOW(a_sweep_in_range, clock, reset,
      wv_ff, (int'(widx_ff) < int'(tracks_lim_ff)) && (state_ff == S_SWEEP))

endmodule
